@@ src/mcpd_pkg.sv @@
// mcpd_pkg: shared constants, types and codes for the min cost plus distance table.
// Used by the interfaces, the controller, the datapath and the checker.
package mcpd_pkg;

	// table geometry (DEPTH is a whole number of blocks)
	localparam int DEPTH      = 1024;
	localparam int BLOCK_SIZE = 32;
	localparam int NUM_BLOCKS = DEPTH / BLOCK_SIZE;

	localparam int EW = $clog2(DEPTH);       // entry index
	localparam int OW = $clog2(BLOCK_SIZE);  // offset within a block
	localparam int BW = $clog2(NUM_BLOCKS);  // block index

	// word field widths
	localparam int POS_W   = 10;
	localparam int COST_W  = 30;
	localparam int TOTAL_W = 31;
	localparam int CNT_W   = 11;

	localparam logic [TOTAL_W-1:0] ABSENT      = '1;
	localparam logic [CNT_W-1:0]   CNT_RESET   = CNT_W'(DEPTH);

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_RB_SCAN,
		ST_RB_DRAIN,
		ST_RB_STORE,
		ST_Q_BLK,
		ST_Q_SCAN,
		ST_Q_DRAIN,
		ST_Q_DONE
	} state_t;

	// what the datapath does with the read data in the cycle after the read
	typedef enum logic [2:0] {
		EV_NONE,
		EV_ENTRY,
		EV_LMIN,
		EV_RMIN,
		EV_REBUILD
	} eval_t;

	typedef struct packed {
		logic          load;      // capture input word, reset accumulators
		logic          clear;     // clearing pass write
		logic          cost_we;
		logic          min_we;
		logic          push;      // move result into output register
		eval_t         eval;
		logic [EW-1:0] entry;
		logic [BW-1:0] blk;
		logic [OW-1:0] ofs;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

@@ src/mcpd_item_if.sv @@
// mcpd_item_if: input word channel (operation, position, cost_value).
// Depends on mcpd_pkg.
interface mcpd_item_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [mcpd_pkg::POS_W-1:0]   position;
	logic [mcpd_pkg::COST_W-1:0]  cost_value;

	modport source(output valid, operation, position, cost_value, input ready);
	modport sink(input valid, operation, position, cost_value, output ready);
endinterface

@@ src/mcpd_result_if.sv @@
// mcpd_result_if: result word channel (min_total, found).
// Depends on mcpd_pkg.
interface mcpd_result_if;
	logic                          valid;
	logic                          ready;
	logic [mcpd_pkg::TOTAL_W-1:0]  min_total;
	logic                          found;

	modport source(output valid, min_total, found, input ready);
	modport sink(input valid, min_total, found, output ready);
endinterface

@@ src/mcpd_cfg_if.sv @@
// mcpd_cfg_if: configuration write channel carrying entry_count.
// Depends on mcpd_pkg.
interface mcpd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mcpd_pkg::CNT_W-1:0]  data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ src/min_cost_plus_distance_table.sv @@
// min_cost_plus_distance_table: top level, controller plus datapath.
// Write: accepted, then store, 32-entry block rescan, drain and minima store.
// Query: walks the blocks, taking a summarized block by its minima and scanning the
//   entries of a directly scanned block (own block, block cut by entry_count), then
//   drain and result load; the result load is held while the previous result
//   waits. One word in flight; the cost store read port sets it.
// Reset: entry_count = 1024, then a clearing pass over all 1024 entries with input ready low.
module min_cost_plus_distance_table (
	input  logic         clk,
	input  logic         arst_n,
	mcpd_item_if.sink    item,
	mcpd_result_if.source result,
	mcpd_cfg_if.sink     cfg
);

	// command / status between sequencer and datapath
	mcpd_pkg::dp_cmd_t  cmd;
	mcpd_pkg::dp_stat_t stat;

	// Sequencer: clearing pass, write + block rebuild, query walk over blocks.
	// Also owns entry_count (cfg writes land at any time; only idle by contract).
	mcpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (item.valid),
		.in_ready     (item.ready),
		.in_operation (item.operation),
		.in_position  (item.position),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_data     (cfg.data),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Datapath: cost store (1024 x 31), left/right block minima (32 x 31 each),
	// one evaluation stage behind the read ports, min accumulators, and the
	// result register that lets the next word in while a result waits.
	mcpd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_position   (item.position),
		.in_cost_value (item.cost_value),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_min_total (result.min_total),
		.out_found     (result.found)
	);

endmodule

@@ src/mcpd_ctrl.sv @@
// mcpd_ctrl: sequencer for clearing pass, write/rebuild and query walk.
// Holds entry_count; drives the datapath through mcpd_pkg::dp_cmd_t.
module mcpd_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_operation,
	input  logic [mcpd_pkg::POS_W-1:0]   in_position,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mcpd_pkg::CNT_W-1:0]   cfg_data,
	input  mcpd_pkg::dp_stat_t           stat,
	output mcpd_pkg::dp_cmd_t            cmd
);

	mcpd_pkg::state_t                state_q, state_d;
	logic [mcpd_pkg::EW-1:0]         cnt_q, cnt_d;
	logic [mcpd_pkg::BW-1:0]         blk_q, blk_d;
	logic [mcpd_pkg::OW-1:0]         ofs_q, ofs_d;
	logic [mcpd_pkg::BW-1:0]         pos_blk_q, pos_blk_d;
	logic [mcpd_pkg::CNT_W-1:0]      entry_count_q;

	logic [mcpd_pkg::CNT_W-1:0]      valid_n;
	logic [mcpd_pkg::CNT_W-1:0]      blk_start;
	logic [mcpd_pkg::CNT_W-1:0]      blk_end;
	logic [mcpd_pkg::CNT_W-1:0]      cur_j;
	logic                            last_blk;
	logic                            scan_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= mcpd_pkg::CNT_RESET;
		end else if (cfg_valid) begin
			entry_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mcpd_pkg::ST_CLEAR;
			cnt_q     <= '0;
			blk_q     <= '0;
			ofs_q     <= '0;
			pos_blk_q <= '0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			blk_q     <= blk_d;
			ofs_q     <= ofs_d;
			pos_blk_q <= pos_blk_d;
		end
	end

	// entries at or above valid_n are absent
	assign valid_n   = (entry_count_q > mcpd_pkg::CNT_RESET) ? mcpd_pkg::CNT_RESET
		: entry_count_q;
	assign blk_start = mcpd_pkg::CNT_W'({blk_q, {mcpd_pkg::OW{1'b0}}});
	assign blk_end   = blk_start + mcpd_pkg::CNT_W'(mcpd_pkg::BLOCK_SIZE - 1);
	assign cur_j     = mcpd_pkg::CNT_W'({blk_q, ofs_q});
	assign last_blk  = (blk_q == mcpd_pkg::BW'(mcpd_pkg::NUM_BLOCKS - 1));
	assign scan_last = (ofs_q == mcpd_pkg::OW'(mcpd_pkg::BLOCK_SIZE - 1))
		|| ((cur_j + mcpd_pkg::CNT_W'(1)) >= valid_n);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		blk_d     = blk_q;
		ofs_d     = ofs_q;
		pos_blk_d = pos_blk_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.eval  = mcpd_pkg::EV_NONE;

		unique case (state_q)
			mcpd_pkg::ST_CLEAR: begin
				cmd.clear   = 1'b1;
				cmd.cost_we = 1'b1;
				cmd.entry   = cnt_q;
				cmd.min_we  = (cnt_q < mcpd_pkg::EW'(mcpd_pkg::NUM_BLOCKS));
				cmd.blk     = cnt_q[mcpd_pkg::BW-1:0];
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == mcpd_pkg::EW'(mcpd_pkg::DEPTH - 1)) begin
					state_d = mcpd_pkg::ST_IDLE;
				end
			end
			mcpd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					pos_blk_d = in_position[mcpd_pkg::EW-1:mcpd_pkg::OW];
					blk_d     = '0;
					ofs_d     = '0;
					state_d   = (in_operation == mcpd_pkg::OP_WRITE) ? mcpd_pkg::ST_WRITE
						: mcpd_pkg::ST_Q_BLK;
				end
			end
			mcpd_pkg::ST_WRITE: begin
				cmd.cost_we = 1'b1;
				state_d     = mcpd_pkg::ST_RB_SCAN;
			end
			mcpd_pkg::ST_RB_SCAN: begin
				cmd.eval  = mcpd_pkg::EV_REBUILD;
				cmd.entry = {pos_blk_q, ofs_q};
				cmd.ofs   = ofs_q;
				ofs_d     = ofs_q + 1'b1;
				if (ofs_q == mcpd_pkg::OW'(mcpd_pkg::BLOCK_SIZE - 1)) begin
					state_d = mcpd_pkg::ST_RB_DRAIN;
				end
			end
			mcpd_pkg::ST_RB_DRAIN: begin
				state_d = mcpd_pkg::ST_RB_STORE;
			end
			mcpd_pkg::ST_RB_STORE: begin
				cmd.min_we = 1'b1;
				cmd.blk    = pos_blk_q;
				state_d    = mcpd_pkg::ST_IDLE;
			end
			mcpd_pkg::ST_Q_BLK: begin
				cmd.blk = blk_q;
				if (blk_start >= valid_n) begin
					state_d = mcpd_pkg::ST_Q_DRAIN;
				end else if (blk_q == pos_blk_q || blk_end >= valid_n) begin
					// own block or block cut by entry_count: scan entries
					state_d = mcpd_pkg::ST_Q_SCAN;
				end else begin
					cmd.eval = (blk_q < pos_blk_q) ? mcpd_pkg::EV_RMIN : mcpd_pkg::EV_LMIN;
					blk_d    = blk_q + 1'b1;
					if (last_blk) begin
						state_d = mcpd_pkg::ST_Q_DRAIN;
					end
				end
			end
			mcpd_pkg::ST_Q_SCAN: begin
				cmd.entry = {blk_q, ofs_q};
				if (cur_j < valid_n) begin
					cmd.eval = mcpd_pkg::EV_ENTRY;
				end
				if (scan_last) begin
					ofs_d   = '0;
					blk_d   = blk_q + 1'b1;
					state_d = last_blk ? mcpd_pkg::ST_Q_DRAIN : mcpd_pkg::ST_Q_BLK;
				end else begin
					ofs_d = ofs_q + 1'b1;
				end
			end
			mcpd_pkg::ST_Q_DRAIN: begin
				state_d = mcpd_pkg::ST_Q_DONE;
			end
			mcpd_pkg::ST_Q_DONE: begin
				if (!stat.out_busy) begin
					cmd.push = 1'b1;
					state_d  = mcpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mcpd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/mcpd_dp.sv @@
// mcpd_dp: cost store, block minima stores, evaluation stage, accumulators
// and result register. Driven by mcpd_ctrl; depends on mcpd_pkg.
module mcpd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcpd_pkg::dp_cmd_t             cmd,
	output mcpd_pkg::dp_stat_t            stat,
	input  logic [mcpd_pkg::POS_W-1:0]    in_position,
	input  logic [mcpd_pkg::COST_W-1:0]   in_cost_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mcpd_pkg::TOTAL_W-1:0]  out_min_total,
	output logic                          out_found
);

	logic [mcpd_pkg::TOTAL_W-1:0] cost_mem  [mcpd_pkg::DEPTH];
	logic [mcpd_pkg::TOTAL_W-1:0] left_mem  [mcpd_pkg::NUM_BLOCKS];
	logic [mcpd_pkg::TOTAL_W-1:0] right_mem [mcpd_pkg::NUM_BLOCKS];

	logic [mcpd_pkg::EW-1:0]      pos_q;
	logic [mcpd_pkg::COST_W-1:0]  cost_q;

	logic [mcpd_pkg::TOTAL_W-1:0] rd_cost_s1, rd_left_s1, rd_right_s1;
	mcpd_pkg::eval_t              eval_s1;
	logic [mcpd_pkg::EW-1:0]      entry_s1;
	logic [mcpd_pkg::BW-1:0]      blk_s1;
	logic [mcpd_pkg::OW-1:0]      ofs_s1;

	logic [mcpd_pkg::TOTAL_W-1:0] best_q, lo_q, hi_q;
	logic                         found_q;
	logic                         out_valid_q;
	logic [mcpd_pkg::TOTAL_W-1:0] out_total_q;
	logic                         out_found_q;

	logic [mcpd_pkg::EW-1:0]      cost_waddr;
	logic [mcpd_pkg::TOTAL_W-1:0] cost_wdata, lo_wdata, hi_wdata;
	logic [mcpd_pkg::EW-1:0]      blk_lo, blk_hi, gap;
	logic [mcpd_pkg::TOTAL_W-1:0] cand_m, cand_t, rb_lo, rb_hi;
	logic                         cand_ok;

	function automatic logic [mcpd_pkg::TOTAL_W-1:0] sat_add(
		input logic [mcpd_pkg::TOTAL_W-1:0] a,
		input logic [mcpd_pkg::EW-1:0]      d
	);
		logic [mcpd_pkg::TOTAL_W:0] s;
		s = {1'b0, a} + (mcpd_pkg::TOTAL_W + 1)'(d);
		return s[mcpd_pkg::TOTAL_W] ? mcpd_pkg::ABSENT : s[mcpd_pkg::TOTAL_W-1:0];
	endfunction

	// write port selection
	assign cost_waddr = cmd.clear ? cmd.entry : pos_q;
	assign cost_wdata = cmd.clear ? mcpd_pkg::ABSENT : {1'b0, cost_q};
	assign lo_wdata   = cmd.clear ? mcpd_pkg::ABSENT : lo_q;
	assign hi_wdata   = cmd.clear ? mcpd_pkg::ABSENT : hi_q;

	always_ff @(posedge clk) begin
		if (cmd.cost_we) begin
			cost_mem[cost_waddr] <= cost_wdata;
		end
		rd_cost_s1 <= cost_mem[cmd.entry];
	end

	always_ff @(posedge clk) begin
		if (cmd.min_we) begin
			left_mem[cmd.blk]  <= lo_wdata;
			right_mem[cmd.blk] <= hi_wdata;
		end
		rd_left_s1  <= left_mem[cmd.blk];
		rd_right_s1 <= right_mem[cmd.blk];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= mcpd_pkg::EV_NONE;
		end else begin
			eval_s1 <= cmd.eval;
		end
	end

	always_ff @(posedge clk) begin
		entry_s1 <= cmd.entry;
		blk_s1   <= cmd.blk;
		ofs_s1   <= cmd.ofs;
		if (cmd.load) begin
			pos_q  <= in_position[mcpd_pkg::EW-1:0];
			cost_q <= in_cost_value;
		end
	end

	// distances: entry to query point, or block edge to query point
	assign blk_lo = {blk_s1, {mcpd_pkg::OW{1'b0}}};
	assign blk_hi = {blk_s1, {mcpd_pkg::OW{1'b1}}};

	always_comb begin
		cand_m = mcpd_pkg::ABSENT;
		gap    = '0;
		unique case (eval_s1)
			mcpd_pkg::EV_ENTRY: begin
				cand_m = rd_cost_s1;
				gap    = (entry_s1 > pos_q) ? (entry_s1 - pos_q) : (pos_q - entry_s1);
			end
			mcpd_pkg::EV_RMIN: begin
				cand_m = rd_right_s1;
				gap    = pos_q - blk_hi;
			end
			mcpd_pkg::EV_LMIN: begin
				cand_m = rd_left_s1;
				gap    = blk_lo - pos_q;
			end
			default: begin
				cand_m = mcpd_pkg::ABSENT;
			end
		endcase
	end

	assign cand_ok = (cand_m != mcpd_pkg::ABSENT);
	assign cand_t  = sat_add(cand_m, gap);
	assign rb_lo   = sat_add(rd_cost_s1, mcpd_pkg::EW'(ofs_s1));
	assign rb_hi   = sat_add(rd_cost_s1,
		mcpd_pkg::EW'(mcpd_pkg::OW'(mcpd_pkg::BLOCK_SIZE - 1) - ofs_s1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_q  <= mcpd_pkg::ABSENT;
			found_q <= 1'b0;
			lo_q    <= mcpd_pkg::ABSENT;
			hi_q    <= mcpd_pkg::ABSENT;
		end else if (eval_s1 == mcpd_pkg::EV_REBUILD) begin
			if (rd_cost_s1 != mcpd_pkg::ABSENT) begin
				if (rb_lo < lo_q) begin
					lo_q <= rb_lo;
				end
				if (rb_hi < hi_q) begin
					hi_q <= rb_hi;
				end
			end
		end else if (cand_ok) begin
			found_q <= 1'b1;
			if (cand_t < best_q) begin
				best_q <= cand_t;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_total_q <= found_q ? best_q : mcpd_pkg::ABSENT;
			out_found_q <= found_q;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_min_total = out_total_q;
	assign out_found     = out_found_q;

endmodule

@@ src/mcpd_checker.sv @@
// mcpd_checker: port-level checks on min_cost_plus_distance_table, bound in below.
// Depends on mcpd_pkg.
module mcpd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [mcpd_pkg::TOTAL_W-1:0]  res_total,
	input logic                          res_found
);

	// nothing found means saturated total
	a_absent_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_total == mcpd_pkg::ABSENT)
		else $error("found=0 with unsaturated total");

	// a found total is a real sum, never the absent marker
	a_found_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found |-> res_total != mcpd_pkg::ABSENT)
		else $error("found=1 with absent total");

	// one word at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input ready right after accept");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_total) && $stable(res_found))
		else $error("result dropped or changed while stalled");

endmodule

bind min_cost_plus_distance_table mcpd_checker u_mcpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_total  (result.min_total),
	.res_found  (result.found)
);
